/* rtl/core/rwcp_pkg.sv */
// ----------------------------------------------------------------------------
// rwcp_pkg
// Shared types and codes for the RIFF/WAVE chunk parser.
// ----------------------------------------------------------------------------
package rwcp_pkg;

   // request beat: one raw byte of the file
   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   // response beat: one per request beat
   typedef struct packed {
      logic [2:0]  byte_class;
      logic [7:0]  byte_echo;
      logic [1:0]  error_code;
      logic [15:0] audio_format;
      logic [15:0] num_channels;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
      logic        parse_done;
   } rsp_type;

   // parser phases
   localparam logic [2:0] PH_OUTER = 3'd0;
   localparam logic [2:0] PH_SUB   = 3'd1;
   localparam logic [2:0] PH_BODY  = 3'd2;
   localparam logic [2:0] PH_DONE  = 3'd3;
   localparam logic [2:0] PH_HALT  = 3'd4;

   // byte classes
   localparam logic [2:0] CLS_RIFF_HDR = 3'd0;
   localparam logic [2:0] CLS_SUB_HDR  = 3'd1;
   localparam logic [2:0] CLS_FMT      = 3'd2;
   localparam logic [2:0] CLS_DATA     = 3'd3;
   localparam logic [2:0] CLS_OTHER    = 3'd4;
   localparam logic [2:0] CLS_TRAILING = 3'd5;

   // error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_NOT_RIFF = 2'd1;
   localparam logic [1:0] ERR_TRUNC = 2'd2;
   localparam logic [1:0] ERR_RSVD  = 2'd3;

   // body kinds
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_FMT   = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;

   // header geometry
   localparam logic [3:0] ID_LEN        = 4'd4;
   localparam logic [3:0] SUB_HDR_LEN   = 4'd8;
   localparam logic [3:0] OUTER_HDR_LEN = 4'd12;
   localparam logic [4:0] FMT_DECODE_LEN = 5'd16;

   // chunk identifiers, first byte most significant
   localparam logic [31:0] ID_RIFF = 32'h5249_4646;
   localparam logic [31:0] ID_FMT  = 32'h666d_7420;
   localparam logic [31:0] ID_DATA = 32'h6461_7461;

endpackage

/* rtl/core/riff_wave_chunk_parser.sv */
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser
// Byte-wide RIFF/WAVE walker: outer header check, sub-chunk headers, fmt decode.
// ----------------------------------------------------------------------------
// Response: registered; an accepted request beat shows on rsp in the next cycle.
// Throughput: 1 byte per cycle unless rsp_ready stalls; parse state and rsp
//    register both update at the accepting edge, so beats stream back to back.
// Backpressure: req_ready is high while the response register is empty or drains.
// Reset: synchronous, active high; clears the parse state, the fmt fields, the
//    error latch and the response valid.
module riff_wave_chunk_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rwcp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rwcp_pkg::rsp_type rsp_payload
);
   import rwcp_pkg::*;

   // parse state
   logic [2:0]  phase_ff,      phase_in;
   logic [3:0]  hdr_cnt_ff,    hdr_cnt_in;
   logic [31:0] id_shift_ff,   id_shift_in;
   logic [31:0] size_shift_ff, size_shift_in;
   logic [31:0] outer_left_ff, outer_left_in;   // size field is 32 bits, never grows
   logic [31:0] body_left_ff,  body_left_in;
   logic [4:0]  fmt_off_ff,    fmt_off_in;
   logic [1:0]  kind_ff,       kind_in;
   logic [63:0] fmt_lo_ff,     fmt_lo_in;       // fmt body bytes 0..7
   logic [63:0] fmt_hi_ff,     fmt_hi_in;       // fmt body bytes 8..15
   logic [1:0]  err_ff,        err_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;

   logic       accept;
   logic [2:0] cls;
   logic [3:0] hdr_cnt_inc;
   logic [7:0] b;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign b           = req_payload.byte_value;
   assign hdr_cnt_inc = hdr_cnt_ff + 4'd1;

   always_comb begin
      phase_in      = phase_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      id_shift_in   = id_shift_ff;
      size_shift_in = size_shift_ff;
      outer_left_in = outer_left_ff;
      body_left_in  = body_left_ff;
      fmt_off_in    = fmt_off_ff;
      kind_in       = kind_ff;
      fmt_lo_in     = fmt_lo_ff;
      fmt_hi_in     = fmt_hi_ff;
      err_in        = err_ff;
      cls           = CLS_TRAILING;

      unique case (phase_ff)
         PH_OUTER: begin
            cls        = CLS_RIFF_HDR;
            hdr_cnt_in = hdr_cnt_inc;
            // id + size bytes shift in; form tag bytes count down the outer size
            if (hdr_cnt_ff < SUB_HDR_LEN) begin
               if (hdr_cnt_ff < ID_LEN) begin
                  id_shift_in = {id_shift_ff[23:0], b};
               end else begin
                  size_shift_in = {b, size_shift_ff[31:8]};
               end
            end else if (outer_left_ff != 32'd0) begin
               outer_left_in = outer_left_ff - 32'd1;
            end
            if (hdr_cnt_inc == ID_LEN && id_shift_in != ID_RIFF) begin
               err_in   = ERR_NOT_RIFF;
               phase_in = PH_HALT;
            end else if (hdr_cnt_inc == SUB_HDR_LEN) begin
               outer_left_in = size_shift_in;
            end else if (hdr_cnt_inc >= OUTER_HDR_LEN) begin
               hdr_cnt_in = 4'd0;
               phase_in   = (outer_left_in == 32'd0) ? PH_DONE : PH_SUB;
            end
         end
         PH_SUB: begin
            cls        = CLS_SUB_HDR;
            hdr_cnt_in = hdr_cnt_inc;
            if (hdr_cnt_ff < ID_LEN) begin
               id_shift_in = {id_shift_ff[23:0], b};
            end else begin
               size_shift_in = {b, size_shift_ff[31:8]};
            end
            if (outer_left_ff != 32'd0) begin
               outer_left_in = outer_left_ff - 32'd1;
            end
            if (hdr_cnt_inc >= SUB_HDR_LEN) begin
               body_left_in = size_shift_in;
               if (id_shift_in == ID_FMT) begin
                  // a new fmt chunk restarts the decode from zero
                  kind_in    = KIND_FMT;
                  fmt_off_in = 5'd0;
                  fmt_lo_in  = 64'd0;
                  fmt_hi_in  = 64'd0;
               end else if (id_shift_in == ID_DATA) begin
                  kind_in = KIND_DATA;
               end else begin
                  kind_in = KIND_OTHER;
               end
               if (size_shift_in == 32'd0) begin
                  hdr_cnt_in = 4'd0;
                  phase_in   = (outer_left_in == 32'd0) ? PH_DONE : PH_SUB;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            unique case (kind_ff)
               KIND_FMT:  cls = CLS_FMT;
               KIND_DATA: cls = CLS_DATA;
               default:   cls = CLS_OTHER;
            endcase
            if (kind_ff == KIND_FMT && fmt_off_ff < FMT_DECODE_LEN) begin
               if (!fmt_off_ff[3]) begin
                  fmt_lo_in[{fmt_off_ff[2:0], 3'b000} +: 8] = b;
               end else begin
                  fmt_hi_in[{fmt_off_ff[2:0], 3'b000} +: 8] = b;
               end
               fmt_off_in = fmt_off_ff + 5'd1;
            end
            if (outer_left_ff != 32'd0) begin
               outer_left_in = outer_left_ff - 32'd1;
            end
            if (body_left_ff != 32'd0) begin
               body_left_in = body_left_ff - 32'd1;
            end
            if (body_left_in == 32'd0) begin
               hdr_cnt_in = 4'd0;
               phase_in   = (outer_left_in == 32'd0) ? PH_DONE : PH_SUB;
            end
         end
         default: begin
            cls = CLS_TRAILING;   // done or halted: everything is trailing
         end
      endcase

      // end of buffer short of a chunk boundary
      if (req_payload.last_byte && phase_in != PH_DONE && phase_in != PH_HALT) begin
         if (err_in == ERR_NONE) begin
            err_in = ERR_TRUNC;
         end
         phase_in = PH_HALT;
      end
   end

   always_comb begin
      rsp_data_in.byte_class      = cls;
      rsp_data_in.byte_echo       = b;
      rsp_data_in.error_code      = err_in;
      rsp_data_in.audio_format    = fmt_lo_in[15:0];
      rsp_data_in.num_channels    = fmt_lo_in[31:16];
      rsp_data_in.sample_rate     = fmt_lo_in[63:32];
      rsp_data_in.byte_rate       = fmt_hi_in[31:0];
      rsp_data_in.block_align     = fmt_hi_in[47:32];
      rsp_data_in.bits_per_sample = fmt_hi_in[63:48];
      rsp_data_in.parse_done      = (phase_in == PH_DONE);
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_OUTER;
         hdr_cnt_ff    <= 4'd0;
         id_shift_ff   <= 32'd0;
         size_shift_ff <= 32'd0;
         outer_left_ff <= 32'd0;
         body_left_ff  <= 32'd0;
         fmt_off_ff    <= 5'd0;
         kind_ff       <= KIND_OTHER;
         fmt_lo_ff     <= 64'd0;
         fmt_hi_ff     <= 64'd0;
         err_ff        <= ERR_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            hdr_cnt_ff    <= hdr_cnt_in;
            id_shift_ff   <= id_shift_in;
            size_shift_ff <= size_shift_in;
            outer_left_ff <= outer_left_in;
            body_left_ff  <= body_left_in;
            fmt_off_ff    <= fmt_off_in;
            kind_ff       <= kind_in;
            fmt_lo_ff     <= fmt_lo_in;
            fmt_hi_ff     <= fmt_hi_in;
            err_ff        <= err_in;
         end
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

/* rtl/core/rwcp_checker.sv */
// ----------------------------------------------------------------------------
// rwcp_checker
// Port-level checks for the RIFF/WAVE chunk parser.
// ----------------------------------------------------------------------------
module rwcp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rwcp_pkg::rsp_type rsp_payload
);
   import rwcp_pkg::*;

   // error code last delivered; an error never clears short of reset
   logic [1:0] seen_err_ff, seen_err_in;

   assign seen_err_in = (rsp_valid && rsp_ready) ? rsp_payload.error_code : seen_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_err_ff <= ERR_NONE;
      end else begin
         seen_err_ff <= seen_err_in;
      end
   end

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   // every accepted request yields a response on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted req beat produced no rsp beat");

   // empty output stage never blocks input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output stage");

   // error latch sticks
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_err_ff != ERR_NONE |-> rsp_payload.error_code == seen_err_ff)
      else $error("latched error code changed");

   // done and error exclude each other
   a_done_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.parse_done |-> rsp_payload.error_code == ERR_NONE)
      else $error("parse_done with an error code");

endmodule

bind riff_wave_chunk_parser rwcp_checker u_rwcp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

/* tb/riff_parse_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_parse_monitor
// Watches both channels of the RIFF/WAVE chunk parser. It runs its own model
// of the byte walk on every accepted request beat and checks each accepted
// response beat, field by field, against the oldest predicted beat.
// ----------------------------------------------------------------------------
module riff_parse_monitor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  rwcp_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rwcp_pkg::rsp_type rsp_payload,
   output int                mismatches,
   output int                outstanding
);
   import rwcp_pkg::*;

   // walk state
   logic [2:0]  phase;
   logic [3:0]  hdr_count;
   logic [31:0] id_sr;
   logic [31:0] size_sr;
   logic [32:0] outer_left;
   logic [31:0] body_left;
   logic [4:0]  fmt_off;
   logic [1:0]  body_kind;
   logic [63:0] fmt_lo;
   logic [63:0] fmt_hi;
   logic [1:0]  err_latch;

   rsp_type predicted_beats[$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic take_outer_byte();
      if (outer_left != 0) outer_left--;
   endtask

   task automatic close_chunk();
      hdr_count = 0;
      phase = (outer_left == 0) ? PH_DONE : PH_SUB;
   endtask

   // ids shift in first byte on top, sizes assemble little-endian
   task automatic shift_header(input logic [7:0] b);
      if (hdr_count < ID_LEN) id_sr = {id_sr[23:0], b};
      else size_sr = {b, size_sr[31:8]};
   endtask

   task automatic advance_walk(input req_type beat, output rsp_type pred);
      logic [2:0] cls;
      logic [7:0] b;
      cls = CLS_TRAILING;
      b = beat.byte_value;
      case (phase)
         PH_OUTER: begin
            cls = CLS_RIFF_HDR;
            if (hdr_count < SUB_HDR_LEN) shift_header(b);
            else take_outer_byte();
            hdr_count++;
            if (hdr_count == ID_LEN && id_sr != ID_RIFF) begin
               err_latch = ERR_NOT_RIFF;
               phase = PH_HALT;
            end else if (hdr_count == SUB_HDR_LEN) begin
               outer_left = {1'b0, size_sr};
            end else if (hdr_count >= OUTER_HDR_LEN) begin
               close_chunk();
            end
         end
         PH_SUB: begin
            cls = CLS_SUB_HDR;
            shift_header(b);
            take_outer_byte();
            hdr_count++;
            if (hdr_count >= SUB_HDR_LEN) begin
               body_left = size_sr;
               if (id_sr == ID_FMT) begin
                  body_kind = KIND_FMT;
                  fmt_off = 0;
                  fmt_lo = 0;
                  fmt_hi = 0;
               end else if (id_sr == ID_DATA) begin
                  body_kind = KIND_DATA;
               end else begin
                  body_kind = KIND_OTHER;
               end
               if (body_left == 0) close_chunk();
               else phase = PH_BODY;
            end
         end
         PH_BODY: begin
            cls = (body_kind == KIND_FMT)  ? CLS_FMT :
                  (body_kind == KIND_DATA) ? CLS_DATA : CLS_OTHER;
            if (body_kind == KIND_FMT && fmt_off < FMT_DECODE_LEN) begin
               if (fmt_off < 8) fmt_lo = fmt_lo | (64'(b) << (8 * fmt_off));
               else fmt_hi = fmt_hi | (64'(b) << (8 * (fmt_off - 8)));
               fmt_off++;
            end
            take_outer_byte();
            if (body_left != 0) body_left--;
            if (body_left == 0) close_chunk();
         end
         default: ;
      endcase

      // last byte before the walk finished
      if (beat.last_byte && phase != PH_DONE && phase != PH_HALT) begin
         if (err_latch == ERR_NONE) err_latch = ERR_TRUNC;
         phase = PH_HALT;
      end

      pred.byte_class      = cls;
      pred.byte_echo       = b;
      pred.error_code      = err_latch;
      pred.audio_format    = fmt_lo[15:0];
      pred.num_channels    = fmt_lo[31:16];
      pred.sample_rate     = fmt_lo[63:32];
      pred.byte_rate       = fmt_hi[31:0];
      pred.block_align     = fmt_hi[47:32];
      pred.bits_per_sample = fmt_hi[63:48];
      pred.parse_done      = (phase == PH_DONE);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      rsp_type pred;
      if (reset) begin
         phase = PH_OUTER;
         hdr_count = 0;
         id_sr = 0;
         size_sr = 0;
         outer_left = 0;
         body_left = 0;
         fmt_off = 0;
         body_kind = KIND_OTHER;
         fmt_lo = 0;
         fmt_hi = 0;
         err_latch = ERR_NONE;
         predicted_beats.delete();
      end else begin
         // response first: it belongs to an earlier request beat
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (predicted_beats.size() == 0) begin
               report_mismatch("response beat with nothing pending", 0, 0);
            end else begin
               want = predicted_beats.pop_front();
               if (got.byte_class !== want.byte_class)
                  report_mismatch("byte_class", got.byte_class, want.byte_class);
               if (got.byte_echo !== want.byte_echo)
                  report_mismatch("byte_echo", got.byte_echo, want.byte_echo);
               if (got.error_code !== want.error_code)
                  report_mismatch("error_code", got.error_code, want.error_code);
               if (got.audio_format !== want.audio_format)
                  report_mismatch("audio_format", got.audio_format, want.audio_format);
               if (got.num_channels !== want.num_channels)
                  report_mismatch("num_channels", got.num_channels, want.num_channels);
               if (got.sample_rate !== want.sample_rate)
                  report_mismatch("sample_rate", got.sample_rate, want.sample_rate);
               if (got.byte_rate !== want.byte_rate)
                  report_mismatch("byte_rate", got.byte_rate, want.byte_rate);
               if (got.block_align !== want.block_align)
                  report_mismatch("block_align", got.block_align, want.block_align);
               if (got.bits_per_sample !== want.bits_per_sample)
                  report_mismatch("bits_per_sample", got.bits_per_sample,
                                  want.bits_per_sample);
               if (got.parse_done !== want.parse_done)
                  report_mismatch("parse_done", got.parse_done, want.parse_done);
            end
         end
         if (req_valid && req_ready) begin
            advance_walk(req_payload, pred);
            predicted_beats.insert(predicted_beats.size(), pred);
         end
      end
      outstanding = predicted_beats.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams one RIFF/WAVE byte image into the chunk parser: outer header, a few
// hand-picked sub-chunks (all-ones fmt, empty data, short fmt, empty fmt),
// then random fmt/data/other/near-miss chunks, and a run of trailing bytes.
// The image either ends cleanly (outer size cut short into the last chunk)
// or is truncated by an early last-byte flag. Both sides stall at random, except in the last third.
// ----------------------------------------------------------------------------
module tb;
   import rwcp_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int IMAGE_TARGET = 1750;
   localparam int TRAIL_BYTES  = 40;
   localparam int DRAIN_CYCLES = 4;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   int mismatches;
   int outstanding;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;

   logic [7:0] image_bytes[$];
   bit         image_last[$];
   int         last_chunk_start;

   riff_wave_chunk_parser uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   riff_parse_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver backpressure, redrawn every falling edge
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // append one byte / one last flag to the image
   task automatic add_byte(input logic [7:0] v);
      image_bytes.insert(image_bytes.size(), v);
   endtask

   task automatic add_flag(input bit f);
      image_last.insert(image_last.size(), f);
   endtask

   // one sub-chunk: id first byte on top, LE size, body
   // fill < 0 means random body bytes
   task automatic put_chunk(input logic [31:0] id, input int size, input int fill);
      logic [31:0] sz;
      sz = size;
      last_chunk_start = image_bytes.size();
      for (int j = 3; j >= 0; j--) add_byte(id[8*j +: 8]);
      for (int j = 0; j < 4; j++) add_byte(sz[8*j +: 8]);
      for (int j = 0; j < size; j++)
         add_byte((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
   endtask

   task automatic build_image();
      int          pick;
      int          size;
      int          n;
      int          trunc_at;
      logic [31:0] cid;
      logic [31:0] outer_size;
      logic [31:0] form_tag;

      // outer header; size patched once the image is laid out
      for (int j = 3; j >= 0; j--) add_byte(ID_RIFF[8*j +: 8]);
      for (int j = 0; j < 4; j++) add_byte(8'h00);
      form_tag = $urandom_range(0, 1) ? 32'h5741_5645 : $urandom;
      for (int j = 3; j >= 0; j--) add_byte(form_tag[8*j +: 8]);

      // directed: all-ones fmt, empty data, short fmt, empty fmt (clears)
      put_chunk(ID_FMT, 16, 8'hff);
      put_chunk(ID_DATA, 0, 0);
      put_chunk(ID_FMT, 5, -1);
      put_chunk(ID_FMT, 0, 0);

      // random walk: mostly real chunk types, some noise and near-miss ids
      while (image_bytes.size() < IMAGE_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) cid = ID_FMT;
         else if (pick < 65) cid = ID_DATA;
         else if (pick < 85) cid = $urandom;
         else cid = ($urandom_range(0, 1) ? ID_FMT : ID_DATA) ^
                    (32'h1 << $urandom_range(0, 31));
         if (cid == ID_FMT)
            size = ($urandom_range(0, 3) != 0) ? 16 : $urandom_range(0, 24);
         else
            size = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 40)
                                               : $urandom_range(41, 200);
         put_chunk(cid, size, -1);
      end

      n = image_bytes.size();
      if ($urandom_range(0, 2) == 0) begin
         // outer size too large, then last flag lands inside the final chunk
         outer_size = 32'(n - 8 + int'($urandom_range(1, 1000)));
         trunc_at = $urandom_range(last_chunk_start, n - 1);
      end else begin
         // outer size ends somewhere inside the final chunk: saturates, then done
         outer_size = 32'(n - 8 - int'($urandom_range(0, n - last_chunk_start - 1)));
         trunc_at = -1;
      end
      for (int j = 0; j < 4; j++) image_bytes[4 + j] = outer_size[8*j +: 8];

      for (int i = 0; i < n; i++) add_flag(i == trunc_at);
      if (trunc_at < 0) image_last[n - 1] = 1'($urandom_range(0, 1));

      // trailing bytes after the walk, last flag toggling, final one set
      for (int i = 0; i < TRAIL_BYTES; i++) begin
         add_byte(8'($urandom_range(0, 255)));
         add_flag((i == TRAIL_BYTES - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      build_image();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < image_bytes.size(); i++) begin
         // stall profile: sender light / receiver heavy, swapped, then none
         if (i < image_bytes.size() / 3) begin
            send_idle_pct = 7;
            recv_idle_pct = 45;
         end else if (i < 2 * image_bytes.size() / 3) begin
            send_idle_pct = 45;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
         req_valid = 1'b1;
         req_payload.byte_value = image_bytes[i];
         req_payload.last_byte = image_last[i];
         // hold the beat until it is taken
         do @(posedge clock); while (!req_ready);
         @(negedge clock);
      end
      req_valid = 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/rwcp_pkg.sv
rtl/core/riff_wave_chunk_parser.sv
rtl/core/rwcp_checker.sv
tb/riff_parse_monitor.sv
tb/tb.sv
